// ===== rtl/tns_side_info_parser_defines.svh =====
// Assertion macros shared by the TNS side info parser checker.
// No dependencies; expects clk_i and rst_ni in the scope of use.
`ifndef TNS_SIDE_INFO_PARSER_DEFINES_SVH
`define TNS_SIDE_INFO_PARSER_DEFINES_SVH

// Clocked assertion, disabled during reset.
`define TSIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A valid that is stalled stays valid and keeps its payload.
`define TSIP_ASSERT_HOLD(lbl, vld, rdy, dat, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((vld) && !(rdy) |=> (vld) && $stable(dat))) else $error(msg);

`endif

// ===== rtl/tsip_pkg.sv =====
// Types and constants for the TNS side info parser.
// No dependencies.
package tsip_pkg;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_NFILT    = 8'b0000_0010,
    ST_COEFRES  = 8'b0000_0100,
    ST_LENGTH   = 8'b0000_1000,
    ST_ORDER    = 8'b0001_0000,
    ST_DIR      = 8'b0010_0000,
    ST_COMPRESS = 8'b0100_0000,
    ST_COEF     = 8'b1000_0000
  } parse_state_e;

  typedef enum logic [1:0] {
    KIND_WINDOW = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_COEF   = 2'd2
  } rec_kind_e;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BIT   = 1'b1;

  typedef struct packed {
    logic       op;
    logic       bit_req;
    logic       short_windows;
    logic [3:0] num_windows;
    logic [5:0] num_bands;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [2:0]        window;
    logic [1:0]        filter;
    logic [3:0]        coef_index;
    logic [1:0]        filter_count;
    logic [2:0]        resolution;
    logic [5:0]        first_band;
    logic [5:0]        end_band;
    logic [3:0]        order;
    logic              direction;
    logic signed [3:0] coef;
    logic              last;
  } out_item_t;

endpackage

// ===== rtl/tns_side_info_parser.sv =====
// Bit-serial parser for temporal noise shaping side information.
// Depends on tsip_pkg.
//
// One transaction per cycle on the input: a start transaction loads the window
// mode, window count and band count; each following transaction carries one
// bitstream bit, MSB first. Parser state updates on acceptance and any record
// is written to the output register, so a record appears in the cycle after the
// bit that completes its element. The input stalls only while the output
// register holds a record that has not been taken. Bits arriving outside a
// frame are dropped; a start transaction mid-frame restarts parsing.
module tns_side_info_parser
  import tsip_pkg::*;
#(
  parameter int unsigned MAX_WINDOWS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam logic [3:0] MaxWin = 4'(MAX_WINDOWS);

  parse_state_e st_q, st_d;
  logic [2:0] bits_q, bits_d;
  logic [5:0] shift_q, shift_d;
  logic       short_q, short_d;
  logic [3:0] wt_q, wt_d;
  logic [5:0] bands_q, bands_d;
  logic [2:0] win_q, win_d;
  logic [1:0] fl_q, fl_d;
  logic [1:0] fi_q, fi_d;
  logic [5:0] top_q, top_d;
  logic [2:0] bres_q, bres_d;
  logic [2:0] cbits_q, cbits_d;
  logic [3:0] cl_q, cl_d;
  logic [5:0] start_q, start_d;
  logic       dir_q, dir_d;
  logic [3:0] cpos_q, cpos_d;

  logic      out_valid_q;
  out_item_t out_data_q;
  out_item_t rec;
  logic      rec_v;
  logic      accept;

  logic [5:0] shift_n;
  logic [2:0] bits_n;
  logic       last_win;
  logic       frame_end;
  logic [2:0] len_bits, ord_bits, nf_bits;
  logic [3:0] win_cnt;
  logic [3:0] coef_val;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    st_d = st_q;       bits_d = bits_q;   shift_d = shift_q;  short_d = short_q;
    wt_d = wt_q;       bands_d = bands_q; win_d = win_q;      fl_d = fl_q;
    fi_d = fi_q;       top_d = top_q;     bres_d = bres_q;    cbits_d = cbits_q;
    cl_d = cl_q;       start_d = start_q; dir_d = dir_q;      cpos_d = cpos_q;
    rec        = '0;
    rec.window = win_q;
    rec_v      = 1'b0;
    shift_n    = {shift_q[4:0], in_data_i.bit_req};
    bits_n     = bits_q - 3'd1;
    last_win   = ({1'b0, win_q} + 4'd1) >= wt_q;
    frame_end  = (fl_q == 2'd1) && last_win;
    len_bits   = short_q ? 3'd4 : 3'd6;
    ord_bits   = short_q ? 3'd3 : 3'd4;
    nf_bits    = short_q ? 3'd1 : 3'd2;
    win_cnt    = (in_data_i.num_windows > MaxWin) ? MaxWin : in_data_i.num_windows;
    case (cbits_q)
      3'd2:    coef_val = {{2{shift_n[1]}}, shift_n[1:0]};
      3'd3:    coef_val = {shift_n[2], shift_n[2:0]};
      default: coef_val = shift_n[3:0];
    endcase

    if (accept) begin
      if (in_data_i.op == OP_START) begin
        short_d = in_data_i.short_windows;
        wt_d    = win_cnt;
        bands_d = in_data_i.num_bands;
        win_d   = '0;
        fl_d    = '0;
        fi_d    = '0;
        shift_d = '0;
        if (win_cnt == 4'd0) begin
          st_d   = ST_IDLE;
          bits_d = '0;
        end else begin
          st_d   = ST_NFILT;
          bits_d = in_data_i.short_windows ? 3'd1 : 3'd2;
        end
      end else if (st_q != ST_IDLE && bits_q != 3'd0) begin
        shift_d = shift_n;
        bits_d  = bits_n;
        if (bits_n == 3'd0) begin
          shift_d = '0;
          case (st_q)
            ST_NFILT: begin
              fl_d = shift_n[1:0];
              fi_d = '0;
              if (shift_n[1:0] == 2'd0) begin
                rec.kind = KIND_WINDOW;
                rec.last = last_win;
                rec_v    = 1'b1;
                if (last_win) begin
                  st_d = ST_IDLE;
                end else begin
                  win_d  = win_q + 3'd1;
                  st_d   = ST_NFILT;
                  bits_d = nf_bits;
                end
              end else begin
                st_d   = ST_COEFRES;
                bits_d = 3'd1;
              end
            end
            ST_COEFRES: begin
              bres_d           = 3'd3 + {2'b00, shift_n[0]};
              rec.kind         = KIND_WINDOW;
              rec.filter_count = fl_q;
              rec.resolution   = 3'd3 + {2'b00, shift_n[0]};
              rec_v            = 1'b1;
              top_d            = bands_q;
              st_d             = ST_LENGTH;
              bits_d           = len_bits;
            end
            ST_LENGTH: begin
              start_d = (top_q >= shift_n) ? (top_q - shift_n) : 6'd0;
              st_d    = ST_ORDER;
              bits_d  = ord_bits;
            end
            ST_ORDER: begin
              cl_d = shift_n[3:0];
              if (shift_n[3:0] == 4'd0) begin
                rec.kind       = KIND_HEADER;
                rec.filter     = fi_q;
                rec.first_band = start_q;
                rec.end_band   = top_q;
                rec.last       = frame_end;
                rec_v          = 1'b1;
                top_d = start_q;
                fl_d  = fl_q - 2'd1;
                fi_d  = fi_q + 2'd1;
                if (fl_q != 2'd1) begin
                  st_d   = ST_LENGTH;
                  bits_d = len_bits;
                end else if (last_win) begin
                  st_d = ST_IDLE;
                end else begin
                  win_d  = win_q + 3'd1;
                  st_d   = ST_NFILT;
                  bits_d = nf_bits;
                end
              end else begin
                st_d   = ST_DIR;
                bits_d = 3'd1;
              end
            end
            ST_DIR: begin
              dir_d  = shift_n[0];
              st_d   = ST_COMPRESS;
              bits_d = 3'd1;
            end
            ST_COMPRESS: begin
              cbits_d        = bres_q - {2'b00, shift_n[0]};
              rec.kind       = KIND_HEADER;
              rec.filter     = fi_q;
              rec.resolution = bres_q - {2'b00, shift_n[0]};
              rec.first_band = start_q;
              rec.end_band   = top_q;
              rec.order      = cl_q;
              rec.direction  = dir_q;
              rec_v          = 1'b1;
              cpos_d         = '0;
              st_d           = ST_COEF;
              bits_d         = bres_q - {2'b00, shift_n[0]};
            end
            ST_COEF: begin
              rec.kind       = KIND_COEF;
              rec.filter     = fi_q;
              rec.coef_index = cpos_q;
              rec.coef       = coef_val;
              rec.last       = (cl_q == 4'd1) && frame_end;
              rec_v          = 1'b1;
              cpos_d         = cpos_q + 4'd1;
              cl_d           = cl_q - 4'd1;
              if (cl_q == 4'd1) begin
                top_d = start_q;
                fl_d  = fl_q - 2'd1;
                fi_d  = fi_q + 2'd1;
                if (fl_q != 2'd1) begin
                  st_d   = ST_LENGTH;
                  bits_d = len_bits;
                end else if (last_win) begin
                  st_d = ST_IDLE;
                end else begin
                  win_d  = win_q + 3'd1;
                  st_d   = ST_NFILT;
                  bits_d = nf_bits;
                end
              end else begin
                st_d   = ST_COEF;
                bits_d = cbits_q;
              end
            end
            default: begin
              st_d   = ST_IDLE;
              bits_d = '0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      bits_q  <= '0;
      shift_q <= '0;
      short_q <= 1'b0;
      wt_q    <= 4'd1;
      bands_q <= '0;
      win_q   <= '0;
      fl_q    <= '0;
      fi_q    <= '0;
      top_q   <= '0;
      bres_q  <= 3'd3;
      cbits_q <= 3'd2;
      cl_q    <= '0;
      start_q <= '0;
      dir_q   <= 1'b0;
      cpos_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
      short_q <= short_d;
      wt_q    <= wt_d;
      bands_q <= bands_d;
      win_q   <= win_d;
      fl_q    <= fl_d;
      fi_q    <= fi_d;
      top_q   <= top_d;
      bres_q  <= bres_d;
      cbits_q <= cbits_d;
      cl_q    <= cl_d;
      start_q <= start_d;
      dir_q   <= dir_d;
      cpos_q  <= cpos_d;
      if (in_ready_o) begin
        out_valid_q <= accept && rec_v;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && rec_v) begin
      out_data_q <= rec;
    end
  end

endmodule

// ===== rtl/tsip_checker.sv =====
// Port-level checks for the TNS side info parser, bound to the top level.
// Depends on tsip_pkg and tns_side_info_parser_defines.svh.
`include "tns_side_info_parser_defines.svh"

module tsip_sva
  import tsip_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  `TSIP_ASSERT_HOLD(a_out_hold, out_valid_o, out_ready_i, out_data_o,
                    "output changed while stalled")
  `TSIP_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o,
               "input stalled with empty output")
  `TSIP_ASSERT(a_kind_legal,
               out_valid_o |-> out_data_o.kind == KIND_WINDOW ||
                 out_data_o.kind == KIND_HEADER || out_data_o.kind == KIND_COEF,
               "illegal record kind")
  `TSIP_ASSERT(a_coef_clean,
               out_valid_o && out_data_o.kind == KIND_COEF |->
                 out_data_o.order == 4'd0 && out_data_o.first_band == 6'd0 &&
                 out_data_o.filter_count == 2'd0,
               "coefficient record carries header fields")
  `TSIP_ASSERT(a_start_silent,
               in_valid_i && in_ready_o && in_data_i.op == OP_START |=> !out_valid_o,
               "start transaction produced a record")

endmodule

bind tns_side_info_parser tsip_sva u_tsip_sva (.*);
